/* src/cge_pkg.sv */
// ----------------------------------------------------------------------------
// cge_pkg
// Shared types and constants of the color gradient evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package cge_pkg;
  localparam int unsigned KeySlots = 4;
  localparam int unsigned RegCount = 8;
  localparam logic [40:0] ColorMask = 41'h1FF_FFFF_FFFF;
  localparam logic [24:0] AlphaMask = 25'h1FF_FFFF;
  localparam logic [40:0] ColorKey0Rst = 41'd2199023190016;
  localparam logic [40:0] ColorKey1Rst = 41'd2199023222784;
  localparam logic [24:0] AlphaKey0Rst = 25'd33488896;

  typedef enum logic [2:0] {
    RegCk0 = 3'd0, RegCk1 = 3'd1, RegCk2 = 3'd2, RegCk3 = 3'd3,
    RegAk0 = 3'd4, RegAk1 = 3'd5, RegAk2 = 3'd6, RegAk3 = 3'd7
  } reg_idx_e;

  // one channel lane after key selection
  typedef struct packed {
    logic        lerp;
    logic [7:0]  c0;
    logic [8:0]  dc;    // signed c1-c0
    logic [15:0] dt;    // t - t0
    logic [15:0] den;   // t1 - t0
  } lane_t;
endpackage
`default_nettype wire

/* src/cge_regs.sv */
// ----------------------------------------------------------------------------
// cge_regs
// APB register file holding the color and alpha keys.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic      [40:0] ck_o [4],
  output logic      [24:0] ak_o [4]
);
  logic [40:0] ck_q [4];
  logic [24:0] ak_q [4];
  logic [2:0]  idx;
  logic        wr;

  assign idx = paddr[5:3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ck_q[0] <= cge_pkg::ColorKey0Rst;
      ck_q[1] <= cge_pkg::ColorKey1Rst;
      ck_q[2] <= '0;
      ck_q[3] <= '0;
      ak_q[0] <= cge_pkg::AlphaKey0Rst;
      ak_q[1] <= cge_pkg::AlphaKey0Rst;
      ak_q[2] <= '0;
      ak_q[3] <= '0;
    end else if (wr) begin
      if (!idx[2]) ck_q[idx[1:0]] <= pwdata[40:0];
      else         ak_q[idx[1:0]] <= pwdata[24:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!idx[2]) prdata = {23'd0, ck_q[idx[1:0]]};
    else         prdata = {39'd0, ak_q[idx[1:0]]};
  end

  assign ck_o = ck_q;
  assign ak_o = ak_q;
endmodule
`default_nettype wire

/* src/cge_select.sv */
// ----------------------------------------------------------------------------
// cge_select
// Key search for one channel set: picks key pair and builds a lane.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_select #(
  parameter int unsigned MaxKeys = 4
) (
  input  wire logic [15:0] t_i,
  input  wire logic [15:0] time_i [4],
  input  wire logic [7:0]  chan_i [4],
  input  wire logic [3:0]  used_i,
  output cge_pkg::lane_t   lane_o
);
  logic [2:0] n;
  logic [1:0] sel;
  logic       stop;
  logic       any;

  always_comb begin
    n = 3'd1;
    stop = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (i < MaxKeys && !stop && used_i[i]) n = n + 3'd1;
      else stop = 1'b1;
    end
    sel = 2'd0;
    any = 1'b0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < n && !stop) begin
        if (time_i[i] > t_i) stop = 1'b1;
        else begin
          sel = 2'(i);
          any = 1'b1;
        end
      end
    end
    lane_o.c0   = any ? chan_i[sel] : chan_i[0];
    lane_o.lerp = any && ({1'b0, sel} + 3'd1 < n);
    lane_o.dc   = {1'b0, chan_i[sel + 2'd1]} - {1'b0, chan_i[sel]};
    lane_o.dt   = t_i - time_i[sel];
    lane_o.den  = time_i[sel + 2'd1] - time_i[sel];
  end
endmodule
`default_nettype wire

/* src/cge_blend.sv */
// ----------------------------------------------------------------------------
// cge_blend
// Pipelined blend of one lane: multiply, then 8-bit restoring division
// spread over three stages, then truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_blend (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire cge_pkg::lane_t lane_i,
  output logic [7:0]          c_o
);
  // stage 1: |dc| * dt ; quotient < 256 since dt < den
  logic        lerp1_q, neg1_q;
  logic [7:0]  c01_q;
  logic [23:0] num1_q;
  logic [15:0] den1_q;
  logic [8:0]  mag;
  assign mag = lane_i.dc[8] ? -lane_i.dc : lane_i.dc;

  // divider stages: 3 quotient bits each, but 2 in the last
  logic [23:0] rem_q [3];
  logic [7:0]  quo_q [3];
  logic [15:0] den_q [3];
  logic        lerp_q [3], neg_q [3];
  logic [7:0]  c0_q [3];
  logic [23:0] rem_in [3];
  logic [7:0]  quo_in [3];
  logic [15:0] den_in [3];
  logic        lerp_in [3], neg_in [3];
  logic [7:0]  c0_in [3];
  logic [23:0] rem_d [3];
  logic [7:0]  quo_d [3];

  always_comb begin
    rem_in[0]  = num1_q;
    quo_in[0]  = 8'd0;
    den_in[0]  = den1_q;
    lerp_in[0] = lerp1_q;
    neg_in[0]  = neg1_q;
    c0_in[0]   = c01_q;
    for (int s = 1; s < 3; s++) begin
      rem_in[s]  = rem_q[s-1];
      quo_in[s]  = quo_q[s-1];
      den_in[s]  = den_q[s-1];
      lerp_in[s] = lerp_q[s-1];
      neg_in[s]  = neg_q[s-1];
      c0_in[s]   = c0_q[s-1];
    end
  end

  always_comb begin
    logic [23:0] r;
    logic [7:0]  q;
    logic [39:0] dd;
    for (int s = 0; s < 3; s++) begin
      r = rem_in[s];
      q = quo_in[s];
      dd = '0;
      for (int k = 0; k < 3; k++) begin
        if (7 - (s*3 + k) >= 0) begin
          dd = {24'd0, den_in[s]} << (7 - (s*3 + k));
          if ({16'd0, r} >= dd) begin
            r = r - dd[23:0];
            q[7 - (s*3 + k)] = 1'b1;
          end
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lerp1_q <= lane_i.lerp;
      neg1_q  <= lane_i.dc[8];
      c01_q   <= lane_i.c0;
      num1_q  <= {15'd0, mag} * {8'd0, lane_i.dt};
      den1_q  <= lane_i.den;
      for (int s = 0; s < 3; s++) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_in[s];
        lerp_q[s] <= lerp_in[s];
        neg_q[s]  <= neg_in[s];
        c0_q[s]   <= c0_in[s];
      end
    end
  end

  always_comb begin
    c_o = c0_q[2];
    if (lerp_q[2]) c_o = neg_q[2] ? c0_q[2] - quo_q[2] : c0_q[2] + quo_q[2];
  end
endmodule
`default_nettype wire

/* src/color_gradient_evaluator.sv */
// Pipeline: six register stages (select, multiply, three divider stages,
// output register).
// Throughput: one item per cycle, fully pipelined; the whole pipe stalls only
// while the output register holds an untaken item.
// Reset: async active low, clears valid bits and restores key defaults.
// ----------------------------------------------------------------------------
// color_gradient_evaluator
// Piecewise-linear RGBA gradient with four color and four alpha keys.
// ----------------------------------------------------------------------------
`default_nettype none
module color_gradient_evaluator #(
  parameter int unsigned MAX_KEYS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  red_o,
  output logic      [7:0]  green_o,
  output logic      [7:0]  blue_o,
  output logic      [7:0]  alpha_o
);
  localparam int unsigned Depth = 5;
  logic [40:0] ck [4];
  logic [24:0] ak [4];
  logic [15:0] tm [4][4];
  logic [7:0]  ch [4][4];
  logic [3:0]  us [4];
  cge_pkg::lane_t lane_d [4];
  logic [7:0]  res [4];
  logic [Depth-1:0] vld_q;
  logic        adv;

  assign pready = 1'b1;

  cge_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .ck_o(ck), .ak_o(ak)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tm[0][i] = ck[i][15:0];
      tm[1][i] = ck[i][15:0];
      tm[2][i] = ck[i][15:0];
      tm[3][i] = ak[i][15:0];
      ch[0][i] = ck[i][23:16];
      ch[1][i] = ck[i][31:24];
      ch[2][i] = ck[i][39:32];
      ch[3][i] = ak[i][23:16];
      us[0][i] = ck[i][40];
      us[1][i] = ck[i][40];
      us[2][i] = ck[i][40];
      us[3][i] = ak[i][24];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    cge_pkg::lane_t lane_q;
    cge_select #(.MaxKeys(MAX_KEYS)) u_sel (
      .t_i(sample_time_i), .time_i(tm[g]), .chan_i(ch[g]),
      .used_i(us[g]), .lane_o(lane_d[g])
    );
    always_ff @(posedge clk_i) begin
      if (adv) lane_q <= lane_d[g];
    end
    cge_blend u_blend (.clk_i, .en_i(adv), .lane_i(lane_q), .c_o(res[g]));
  end

  // whole pipe stalls only when the output holds an untaken item
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  logic [7:0] r_q, g_q, b_q, a_q;
  logic       ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= vld_q[Depth-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q <= res[0];
      g_q <= res[1];
      b_q <= res[2];
      a_q <= res[3];
    end
  end
  assign out_valid_o = ov_q;
  assign red_o   = r_q;
  assign green_o = g_q;
  assign blue_o  = b_q;
  assign alpha_o = a_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(alpha_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item lost");
`endif
endmodule
`default_nettype wire

/* tb/color_gradient_evaluator_tb.sv */
// ----------------------------------------------------------------------------
// color_gradient_evaluator_tb
// Drives sample times through the gradient evaluator under several key
// settings, predicts each RGBA item from the programmed keys and checks the
// outputs in order with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module color_gradient_evaluator_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_o, green_o, blue_o, alpha_o;

  logic [40:0] color_keys [cge_pkg::KeySlots];
  logic [24:0] alpha_keys [cge_pkg::KeySlots];
  rgba_t       pending_colors [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          burst_left = 0;
  bit          stall_on = 1'b0;

  color_gradient_evaluator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("color_gradient_evaluator_tb: FAIL");
    $finish;
  end

  function automatic int unsigned used_count(input logic [3:0] used_bits);
    int unsigned n;
    n = 1;
    for (int i = 1; i < cge_pkg::KeySlots; i++) begin
      if (!used_bits[i]) break;
      n++;
    end
    return n;
  endfunction

  // Segment lookup and truncating lerp for one channel set.
  function automatic logic [7:0] lerp_channel(input logic [15:0] t,
      input logic [15:0] times [cge_pkg::KeySlots],
      input logic [7:0] vals [cge_pkg::KeySlots], input int unsigned n);
    int sel;
    int num, den;
    sel = -1;
    for (int i = 0; i < n; i++) begin
      if (times[i] > t) break;
      sel = i;
    end
    if (sel < 0) return vals[0];
    if (sel + 1 >= n) return vals[sel];
    num = (int'(vals[sel+1]) - int'(vals[sel])) * (int'(t) - int'(times[sel]));
    den = int'(times[sel+1]) - int'(times[sel]);
    if (den <= 0) return vals[sel];
    return 8'(int'(vals[sel]) + num / den);
  endfunction

  function automatic rgba_t gradient_color(input logic [15:0] t);
    logic [15:0] ct [cge_pkg::KeySlots];
    logic [15:0] at [cge_pkg::KeySlots];
    logic [7:0]  r [cge_pkg::KeySlots];
    logic [7:0]  g [cge_pkg::KeySlots];
    logic [7:0]  b [cge_pkg::KeySlots];
    logic [7:0]  a [cge_pkg::KeySlots];
    logic [3:0]  cu, au;
    rgba_t       res;
    for (int i = 0; i < cge_pkg::KeySlots; i++) begin
      ct[i] = color_keys[i][15:0];
      r[i]  = color_keys[i][23:16];
      g[i]  = color_keys[i][31:24];
      b[i]  = color_keys[i][39:32];
      cu[i] = color_keys[i][40];
      at[i] = alpha_keys[i][15:0];
      a[i]  = alpha_keys[i][23:16];
      au[i] = alpha_keys[i][24];
    end
    res.red   = lerp_channel(t, ct, r, used_count(cu));
    res.green = lerp_channel(t, ct, g, used_count(cu));
    res.blue  = lerp_channel(t, ct, b, used_count(cu));
    res.alpha = lerp_channel(t, at, a, used_count(au));
    return res;
  endfunction

  task automatic write_reg(input cge_pkg::reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < cge_pkg::RegAk0) color_keys[idx - cge_pkg::RegCk0] = value[40:0];
    else alpha_keys[idx - cge_pkg::RegAk0] = value[24:0];
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [15:0] t);
    if (burst_left == 0) burst_left = $urandom_range(1, 30);
    burst_left--;
    in_valid_i    <= 1'b1;
    sample_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_colors = {pending_colors, gradient_color(t)};
    n_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Receiver: alternating stretches of stalls and full rate.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    out_ready_i <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      rgba_t exp_c;
      if (pending_colors.size() == 0) begin
        $display("%t: unexpected item %h %h %h %h", $time,
                 red_o, green_o, blue_o, alpha_o);
        errors++;
      end else begin
        exp_c = pending_colors.pop_front();
        n_checked++;
        if (red_o !== exp_c.red) begin
          $display("%t: red exp %0d got %0d", $time, exp_c.red, red_o); errors++;
        end
        if (green_o !== exp_c.green) begin
          $display("%t: green exp %0d got %0d", $time, exp_c.green, green_o); errors++;
        end
        if (blue_o !== exp_c.blue) begin
          $display("%t: blue exp %0d got %0d", $time, exp_c.blue, blue_o); errors++;
        end
        if (alpha_o !== exp_c.alpha) begin
          $display("%t: alpha exp %0d got %0d", $time, exp_c.alpha, alpha_o); errors++;
        end
      end
    end
  end

  function automatic logic [40:0] color_key(input logic used, input logic [15:0] t);
    return {used, 8'($urandom), 8'($urandom), 8'($urandom), t};
  endfunction

  function automatic logic [24:0] alpha_key(input logic used, input logic [15:0] t);
    return {used, 8'($urandom), t};
  endfunction

  task automatic run_random(input int count);
    logic [15:0] t;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: t = 16'($urandom);
        1: t = 16'($urandom_range(0, 32768));
        2: t = color_keys[$urandom_range(0, 3)][15:0] + 16'($urandom_range(0, 2)) - 16'd1;
        default: t = alpha_keys[$urandom_range(0, 3)][15:0];
      endcase
      send_sample(t);
    end
  endtask

  task automatic test_reset_keys;
    logic [15:0] pts [8] = '{16'h0000, 16'h0001, 16'h4000, 16'h7FFF,
                             16'h8000, 16'h8001, 16'hFFFE, 16'hFFFF};
    foreach (pts[i]) send_sample(pts[i]);
    drain();
  endtask

  // Four keys, black to full with extremes, falling segments, alpha gaps.
  task automatic test_directed_keys;
    logic [15:0] pts [10] = '{16'h0000, 16'h0FFF, 16'h1000, 16'h2000, 16'h5555,
                              16'h8000, 16'hBFFF, 16'hC000, 16'hE000, 16'hFFFF};
    write_reg(cge_pkg::RegCk0, 64'({1'b0, 24'hFF00FF, 16'h1000}));
    write_reg(cge_pkg::RegCk1, 64'({1'b1, 24'h00FF00, 16'h8000}));
    write_reg(cge_pkg::RegCk2, 64'({1'b1, 24'hFFFFFF, 16'hC000}));
    write_reg(cge_pkg::RegCk3, 64'({1'b1, 24'h000000, 16'hFFFF}));
    write_reg(cge_pkg::RegAk0, 64'({1'b1, 8'hFF, 16'h0000}));
    write_reg(cge_pkg::RegAk1, 64'({1'b1, 8'h00, 16'hFFFF}));
    write_reg(cge_pkg::RegAk2, 64'({1'b1, 8'h80, 16'h0000}));
    write_reg(cge_pkg::RegAk3, 64'({1'b1, 8'hFF, 16'h8000}));
    foreach (pts[i]) send_sample(pts[i]);
    drain();
    // unsorted times and a broken used prefix
    write_reg(cge_pkg::RegCk1, 64'({1'b0, 24'h123456, 16'h2000}));
    write_reg(cge_pkg::RegCk2, 64'({1'b1, 24'hABCDEF, 16'h0800}));
    write_reg(cge_pkg::RegAk1, 64'({1'b1, 8'h10, 16'h4000}));
    write_reg(cge_pkg::RegAk2, 64'({1'b1, 8'hF0, 16'h2000}));
    foreach (pts[i]) send_sample(pts[i]);
    drain();
  endtask

  task automatic test_random_keys(input int phases, input int per_phase);
    logic [15:0] ts [4];
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < 4; i++) ts[i] = 16'($urandom);
      if ($urandom_range(0, 3) != 0) ts.sort();
      write_reg(cge_pkg::RegCk0, 64'(color_key(1'($urandom_range(0, 1)), ts[0])));
      write_reg(cge_pkg::RegCk1, 64'(color_key($urandom_range(0, 5) != 0, ts[1])));
      write_reg(cge_pkg::RegCk2, 64'(color_key($urandom_range(0, 3) != 0, ts[2])));
      write_reg(cge_pkg::RegCk3, 64'(color_key(1'($urandom_range(0, 1)), ts[3])));
      for (int i = 0; i < 4; i++) ts[i] = 16'($urandom);
      if ($urandom_range(0, 3) != 0) ts.sort();
      write_reg(cge_pkg::RegAk0, 64'(alpha_key(1'($urandom_range(0, 1)), ts[0])));
      write_reg(cge_pkg::RegAk1, 64'(alpha_key($urandom_range(0, 5) != 0, ts[1])));
      write_reg(cge_pkg::RegAk2, 64'(alpha_key($urandom_range(0, 3) != 0, ts[2])));
      write_reg(cge_pkg::RegAk3, 64'(alpha_key(1'($urandom_range(0, 1)), ts[3])));
      run_random(per_phase);
      drain();
    end
  endtask

  initial begin
    color_keys = '{cge_pkg::ColorKey0Rst, cge_pkg::ColorKey1Rst, 41'd0, 41'd0};
    alpha_keys = '{cge_pkg::AlphaKey0Rst, cge_pkg::AlphaKey0Rst, 25'd0, 25'd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_keys();
    test_directed_keys();
    test_random_keys(20, 80);
    drain();
    $display("Covered reset keys, directed extremes and 20 random key sets:");
    $display("  %0d samples sent, %0d results checked", n_sent, n_checked);
    if (errors == 0) begin
      $display("color_gradient_evaluator_tb: PASS");
    end else begin
      $display("color_gradient_evaluator_tb: FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
src/cge_pkg.sv
src/cge_regs.sv
src/cge_select.sv
src/cge_blend.sv
src/color_gradient_evaluator.sv
tb/color_gradient_evaluator_tb.sv
